// ===== hdl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg: shared definitions for the first-fit block allocator
// Table geometry, payload structs, entry layout and control codes.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int HEAP_BYTES    = 65536;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int OFS_W         = 16;
    localparam int LEN_W         = 17;
    localparam int FCNT_W        = 11;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REINIT = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_BAD_OFFSET = 2'd2
    } status_t;

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic             is_free;
    } entry_t;

    typedef struct packed {
        op_t              operation;
        logic [LEN_W-1:0] alloc_size;
        logic [OFS_W-1:0] free_offset;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [OFS_W-1:0]  block_offset_out;
        logic [FCNT_W-1:0] blocks_in_use;
        logic [FCNT_W-1:0] free_blocks;
        logic [FCNT_W-1:0] used_blocks;
        logic [LEN_W-1:0]  largest_free_size;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        M_NORMAL,
        M_SKIP1,
        M_SKIP2,
        M_HOLD
    } scan_mode_t;

    localparam entry_t FRESH_ENTRY = '{start: '0, length: LEN_W'(HEAP_BYTES), is_free: 1'b1};

endpackage

// ===== hdl/ffba_cell.sv =====
// ----------------------------------------------------------------------------
// ffba_cell: one table entry of the allocator's shift ring
// Holds one block descriptor and takes its neighbor's entry when the ring moves.
// ----------------------------------------------------------------------------
module ffba_cell (
    input  logic            clk,
    input  logic            shift,
    input  ffba_pkg::entry_t din,
    output ffba_pkg::entry_t dout
);
    import ffba_pkg::*;

    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

// ===== hdl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl: scan controller of the allocator
// Rotates the entry ring once per operation, rewriting entries at the tail
// (split, mark, merge), and gathers the table statistics on the way.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffba_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ffba_pkg::out_item_t out_data,
    input  ffba_pkg::entry_t    head0,
    input  ffba_pkg::entry_t    head1,
    input  ffba_pkg::entry_t    head2,
    output logic                shift,
    output ffba_pkg::entry_t    emit
);
    import ffba_pkg::*;

    localparam int XW = CNT_W + 2;

    ctrl_state_t      state_reg, state_next;
    scan_mode_t       mode_reg, mode_next;
    logic [IDX_W-1:0] t_reg;
    logic             done_reg, done_next;
    op_t              op_reg;
    logic [LEN_W-1:0] want_reg;
    logic [OFS_W-1:0] at_reg;
    entry_t           pend_reg, pend_next;
    logic             pend_real_reg, pend_real_next;
    logic [OFS_W-1:0] where_reg, where_next;
    logic             ins_reg, ins_next;
    logic [1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0] nfree_reg, nused_reg, count_reg;
    logic [LEN_W-1:0] largest_reg;
    logic             fresh_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    entry_t           cur;
    logic             cur_real, nx1_ok, nx2_ok, emit_real, load_out, accept;
    logic [XW-1:0]    t0_x, t1_x, t2_x, cnt_x;
    logic [CNT_W-1:0] new_count;
    status_t          status_val;

    function automatic logic contig(entry_t a, entry_t b);
        logic [OFS_W+1:0] s;
        s = {2'b00, a.start} + {1'b0, a.length};
        return s == {2'b00, b.start};
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (t_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        shift    = (state_reg == S_SCAN);
        load_out = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    end

    assign accept = in_valid && in_ready;

    // Per-beat rewrite of the entry leaving the head of the ring.
    always_comb
    begin
        t0_x  = XW'(t_reg);
        t1_x  = t0_x + XW'(1);
        t2_x  = t0_x + XW'(2);
        cnt_x = XW'(count_reg);
        if (op_reg == OP_REINIT)
        begin
            cur_real = (t_reg == '0);
            nx1_ok   = 1'b0;
            nx2_ok   = 1'b0;
        end
        else
        begin
            cur_real = t0_x < cnt_x;
            nx1_ok   = t1_x < cnt_x;
            nx2_ok   = t2_x < cnt_x;
        end
        if (t_reg == '0 && (fresh_reg || op_reg == OP_REINIT))
        begin
            cur = FRESH_ENTRY;
        end
        else
        begin
            cur = head0;
        end

        emit           = cur;
        emit_real      = cur_real;
        mode_next      = mode_reg;
        done_next      = done_reg;
        ins_next       = ins_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        pend_real_next = pend_real_reg;
        where_next     = where_reg;

        unique case (mode_reg)
            M_NORMAL:
            begin
                if (!done_reg && cur_real && op_reg == OP_ALLOC)
                begin
                    if (want_reg != '0 && cur.is_free && cur.length >= want_reg)
                    begin
                        done_next     = 1'b1;
                        where_next    = cur.start;
                        emit.is_free  = 1'b0;
                        if (cur.length > want_reg && count_reg < CNT_W'(TABLE_ENTRIES))
                        begin
                            // Split: the tail waits in the pending slot and is emitted behind the allocated part.
                            emit.length       = want_reg;
                            pend_next.start   = cur.start + want_reg[OFS_W-1:0];
                            pend_next.length  = cur.length - want_reg;
                            pend_next.is_free = 1'b1;
                            pend_real_next    = 1'b1;
                            ins_next          = 1'b1;
                            mode_next         = M_HOLD;
                        end
                    end
                end
                else if (!done_reg && cur_real && op_reg == OP_FREE)
                begin
                    if (cur.start == at_reg)
                    begin
                        done_next    = 1'b1;
                        emit.is_free = 1'b1;
                        if (nx1_ok && head1.is_free && contig(cur, head1))
                        begin
                            emit.length = cur.length + head1.length;
                            rem_next    = 2'd1;
                            mode_next   = M_SKIP1;
                        end
                    end
                    else if (nx1_ok && head1.start == at_reg && cur.is_free
                             && contig(cur, head1))
                    begin
                        // The freed block joins its free left neighbor.
                        done_next = 1'b1;
                        if (nx2_ok && head2.is_free && contig(head1, head2))
                        begin
                            emit.length = cur.length + head1.length + head2.length;
                            rem_next    = 2'd2;
                            mode_next   = M_SKIP2;
                        end
                        else
                        begin
                            emit.length = cur.length + head1.length;
                            rem_next    = 2'd1;
                            mode_next   = M_SKIP1;
                        end
                    end
                end
            end
            M_SKIP1:
            begin
                emit      = head1;
                emit_real = nx1_ok;
            end
            M_SKIP2:
            begin
                emit      = head2;
                emit_real = nx2_ok;
            end
            M_HOLD:
            begin
                emit           = pend_reg;
                emit_real      = pend_real_reg;
                pend_next      = cur;
                pend_real_next = cur_real;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (op_reg == OP_REINIT)
        begin
            new_count = CNT_W'(1);
        end
        else
        begin
            new_count = count_reg + CNT_W'(ins_reg) - CNT_W'(rem_reg);
        end
        unique case (op_reg)
            OP_ALLOC: status_val = done_reg ? ST_OK : ST_ALLOC_FAIL;
            OP_FREE:  status_val = done_reg ? ST_OK : ST_BAD_OFFSET;
            default:  status_val = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_NORMAL;
            t_reg         <= '0;
            done_reg      <= 1'b0;
            ins_reg       <= 1'b0;
            rem_reg       <= '0;
            count_reg     <= CNT_W'(1);
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                op_reg   <= in_data.operation;
                mode_reg <= M_NORMAL;
                t_reg    <= '0;
                done_reg <= 1'b0;
                ins_reg  <= 1'b0;
                rem_reg  <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                mode_reg <= mode_next;
                t_reg    <= t_reg + IDX_W'(1);
                done_reg <= done_next;
                ins_reg  <= ins_next;
                rem_reg  <= rem_next;
            end
            if (load_out)
            begin
                count_reg     <= new_count;
                fresh_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            want_reg      <= in_data.alloc_size;
            at_reg        <= in_data.free_offset;
            where_reg     <= '0;
            nfree_reg     <= '0;
            nused_reg     <= '0;
            largest_reg   <= '0;
            pend_real_reg <= 1'b0;
        end
        else if (state_reg == S_SCAN)
        begin
            pend_reg      <= pend_next;
            pend_real_reg <= pend_real_next;
            where_reg     <= where_next;
            if (emit_real)
            begin
                if (emit.is_free)
                begin
                    nfree_reg <= nfree_reg + CNT_W'(1);
                    if (emit.length > largest_reg)
                    begin
                        largest_reg <= emit.length;
                    end
                end
                else
                begin
                    nused_reg <= nused_reg + CNT_W'(1);
                end
            end
        end
        if (load_out)
        begin
            out_data_reg.status            <= status_val;
            out_data_reg.block_offset_out  <= (op_reg == OP_ALLOC && done_reg) ? where_reg : '0;
            out_data_reg.blocks_in_use     <= FCNT_W'(new_count);
            out_data_reg.free_blocks       <= FCNT_W'(nfree_reg);
            out_data_reg.used_blocks       <= FCNT_W'(nused_reg);
            out_data_reg.largest_free_size <= largest_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_ins_rem_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ins_reg && rem_reg != 2'd0))
        else $error("split and merge in the same operation");

    a_hold_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && mode_reg == M_HOLD) |-> op_reg == OP_ALLOC)
        else $error("pending slot used outside allocate");

    a_stats_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |->
        (XW'(nfree_reg) + XW'(nused_reg) == XW'(new_count)))
        else $error("free and used counts disagree with table size");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid && state_reg == S_IDLE))
        else $error("result not presented after scan");

endmodule

// ===== hdl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap allocator with split and coalesce
// Block table held as a ring of entry cells, rewritten by one scan per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one command beat:
//   allocate, free or reinitialize. The output channel (out_valid/out_ready/
//   out_data) returns one result beat per command with the status, the block
//   offset and the table statistics after the command.
//   Each command rotates the whole entry ring once, one entry per cycle. The
//   result beat is registered once the scan ends, and the next command is
//   taken only after that result is loaded, so a command occupies the block
//   for the whole rotation; the ring length sets both latency and throughput.
//   The result sits in an output register: a new command is accepted while it
//   waits, and if the receiver still stalls when the next scan ends, the
//   block holds that result until the register frees up.
//   After reset the table holds one free block covering the whole heap; no
//   clearing pass is needed, so the first command is taken right away.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffba_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ffba_pkg::out_item_t out_data
);
    import ffba_pkg::*;

    entry_t cell_q [TABLE_ENTRIES];
    entry_t head   [3];
    entry_t emit;
    logic   shift;

    genvar k;
    generate
        for (k = 0; k < TABLE_ENTRIES; k++)
        begin : g_cell
            entry_t din;
            if (k == TABLE_ENTRIES - 1)
            begin : g_tail
                assign din = emit;
            end
            else
            begin : g_mid
                assign din = cell_q[k+1];
            end
            ffba_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .din   (din),
                .dout  (cell_q[k])
            );
        end
        for (k = 0; k < 3; k++)
        begin : g_head
            if (k < TABLE_ENTRIES)
            begin : g_tap
                assign head[k] = cell_q[k];
            end
            else
            begin : g_none
                assign head[k] = '0;
            end
        end
    endgenerate

    ffba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .head0     (head[0]),
        .head1     (head[1]),
        .head2     (head[2]),
        .shift     (shift),
        .emit      (emit)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for first_fit_block_allocator
// Command beats are driven through the input channel. A behavioral copy of
// the block table predicts every result beat, and each result beat is checked
// field by field in order. The run covers directed corner cases, random
// traffic under several idle and stall mixes, a long receiver hold-off and a
// drain pause.
// ----------------------------------------------------------------------------
module tb;
    import ffba_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    first_fit_block_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the block table.
    logic [OFS_W-1:0] blk_start [TABLE_ENTRIES];
    logic [LEN_W-1:0] blk_len   [TABLE_ENTRIES];
    logic             blk_free  [TABLE_ENTRIES];
    int               blk_count;

    out_item_t pending_results[$];
    int        err_cnt;
    int        beats_sent;
    int        beats_checked;
    int        alloc_fails;
    int        bad_frees;
    int        peak_blocks;
    int        tx_gap_pct;
    int        rx_stall_pct;
    int        rx_hold_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #200ms;
        $display("Timeout at %0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ready = 1'b0;
                rx_hold_cycles--;
            end
            else
            begin
                out_ready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic void table_reset();
        blk_start[0] = '0;
        blk_len[0]   = LEN_W'(HEAP_BYTES);
        blk_free[0]  = 1'b1;
        blk_count    = 1;
    endfunction

    function automatic void drop_entry(int k);
        for (int j = k; j + 1 < blk_count; j++)
        begin
            blk_start[j] = blk_start[j + 1];
            blk_len[j]   = blk_len[j + 1];
            blk_free[j]  = blk_free[j + 1];
        end
        blk_count--;
    endfunction

    function automatic void coalesce_free();
        int i;
        i = 0;
        while (i + 1 < blk_count)
        begin
            if (blk_free[i] && blk_free[i + 1] &&
                int'(blk_start[i]) + int'(blk_len[i]) == int'(blk_start[i + 1]))
            begin
                blk_len[i] = blk_len[i] + blk_len[i + 1];
                drop_entry(i + 1);
            end
            else
            begin
                i++;
            end
        end
    endfunction

    // Applies one command to the shadow table and returns the result beat.
    function automatic out_item_t allocator_apply(in_item_t cmd);
        out_item_t r;
        int        nfree;
        int        nused;
        int        largest;
        bit        found;
        r = '0;
        r.status = ST_OK;
        nfree = 0;
        nused = 0;
        largest = 0;
        found = 1'b0;
        case (cmd.operation)
            OP_ALLOC:
            begin
                r.status = ST_ALLOC_FAIL;
                if (cmd.alloc_size != 0)
                begin
                    for (int i = 0; i < blk_count && !found; i++)
                    begin
                        if (blk_free[i] && blk_len[i] >= cmd.alloc_size)
                        begin
                            found = 1'b1;
                            if (blk_len[i] > cmd.alloc_size && blk_count < TABLE_ENTRIES)
                            begin
                                for (int j = blk_count; j > i + 1; j--)
                                begin
                                    blk_start[j] = blk_start[j - 1];
                                    blk_len[j]   = blk_len[j - 1];
                                    blk_free[j]  = blk_free[j - 1];
                                end
                                blk_start[i + 1] = OFS_W'(int'(blk_start[i]) +
                                                          int'(cmd.alloc_size));
                                blk_len[i + 1]   = blk_len[i] - cmd.alloc_size;
                                blk_free[i + 1]  = 1'b1;
                                blk_len[i]       = cmd.alloc_size;
                                blk_count++;
                            end
                            blk_free[i] = 1'b0;
                            r.status = ST_OK;
                            r.block_offset_out = blk_start[i];
                        end
                    end
                end
            end
            OP_FREE:
            begin
                r.status = ST_BAD_OFFSET;
                for (int i = 0; i < blk_count && !found; i++)
                begin
                    if (blk_start[i] == cmd.free_offset)
                    begin
                        found = 1'b1;
                        blk_free[i] = 1'b1;
                        coalesce_free();
                        r.status = ST_OK;
                    end
                end
            end
            OP_REINIT: table_reset();
            default: ;
        endcase
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_free[i])
            begin
                nfree++;
                if (int'(blk_len[i]) > largest)
                    largest = int'(blk_len[i]);
            end
            else
            begin
                nused++;
            end
        end
        r.blocks_in_use     = FCNT_W'(blk_count);
        r.free_blocks       = FCNT_W'(nfree);
        r.used_blocks       = FCNT_W'(nused);
        r.largest_free_size = LEN_W'(largest);
        return r;
    endfunction

    // Start offset of a random entry with the wanted free mark, if any.
    function automatic bit pick_entry(bit want_free, output logic [OFS_W-1:0] ofs);
        int hits[$];
        for (int i = 0; i < blk_count; i++)
            if (blk_free[i] == want_free)
                hits.push_back(i);
        if (hits.size() == 0)
            return 1'b0;
        ofs = blk_start[hits[$urandom_range(hits.size() - 1)]];
        return 1'b1;
    endfunction

    task automatic send_item(op_t op, logic [LEN_W-1:0] sz, logic [OFS_W-1:0] ofs);
        in_item_t cmd;
        cmd.operation   = op;
        cmd.alloc_size  = sz;
        cmd.free_offset = ofs;
        @(negedge clk);
        if ($urandom_range(99) < tx_gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = cmd;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(allocator_apply(cmd));
        beats_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, out_data);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                beats_checked++;
                if (out_data.status != ST_OK)
                    alloc_fails += (out_data.status == ST_ALLOC_FAIL);
                bad_frees += (out_data.status == ST_BAD_OFFSET);
                if (int'(out_data.blocks_in_use) > peak_blocks)
                    peak_blocks = int'(out_data.blocks_in_use);
                if (out_data.status != want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, out_data.status);
                    err_cnt++;
                end
                if (out_data.block_offset_out != want.block_offset_out)
                begin
                    $display("%0t: block_offset_out expected %0d actual %0d", $time,
                             want.block_offset_out, out_data.block_offset_out);
                    err_cnt++;
                end
                if (out_data.blocks_in_use != want.blocks_in_use)
                begin
                    $display("%0t: blocks_in_use expected %0d actual %0d", $time,
                             want.blocks_in_use, out_data.blocks_in_use);
                    err_cnt++;
                end
                if (out_data.free_blocks != want.free_blocks)
                begin
                    $display("%0t: free_blocks expected %0d actual %0d", $time,
                             want.free_blocks, out_data.free_blocks);
                    err_cnt++;
                end
                if (out_data.used_blocks != want.used_blocks)
                begin
                    $display("%0t: used_blocks expected %0d actual %0d", $time,
                             want.used_blocks, out_data.used_blocks);
                    err_cnt++;
                end
                if (out_data.largest_free_size != want.largest_free_size)
                begin
                    $display("%0t: largest_free_size expected %0d actual %0d", $time,
                             want.largest_free_size, out_data.largest_free_size);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        send_item(OP_ALLOC, 17'd0, 16'hFFFF);
        send_item(OP_ALLOC, 17'h1FFFF, 16'd0);
        send_item(OP_ALLOC, 17'd65536, 16'd0);
        send_item(OP_ALLOC, 17'd1, 16'd0);
        send_item(OP_FREE, 17'h1FFFF, 16'hFFFF);
        send_item(OP_FREE, 17'd0, 16'd0);
        send_item(OP_FREE, 17'd0, 16'd0);
        send_item(OP_ALLOC, 17'd1, 16'hAAAA);
        send_item(OP_ALLOC, 17'd100, 16'h5555);
        send_item(OP_ALLOC, 17'd65435, 16'd0);
        send_item(OP_ALLOC, 17'd1, 16'd0);
        send_item(OP_FREE, 17'd0, 16'd1);
        send_item(OP_FREE, 17'd0, 16'd1);
        send_item(OP_FREE, 17'd0, 16'd0);
        send_item(OP_ALLOC, 17'd50, 16'd0);
        send_item(OP_FREE, 17'd0, 16'd7);
        send_item(OP_NONE, 17'h1FFFF, 16'hFFFF);
        send_item(OP_REINIT, 17'd3, 16'd3);
        send_item(OP_ALLOC, 17'd65535, 16'd0);
        send_item(OP_FREE, 17'd0, 16'd65535);
        send_item(OP_REINIT, 17'd0, 16'd0);
    endtask

    task automatic random_beat();
        int               pick;
        logic [LEN_W-1:0] sz;
        logic [OFS_W-1:0] ofs;
        pick = $urandom_range(99);
        ofs = OFS_W'($urandom);
        if ($urandom_range(9) == 0)
            sz = LEN_W'($urandom);
        else if ($urandom_range(9) == 0)
            sz = LEN_W'($urandom_range(0, 3));
        else
            sz = LEN_W'($urandom_range(1, 4096));
        if (pick < 47)
        begin
            send_item(OP_ALLOC, sz, ofs);
        end
        else if (pick < 82)
        begin
            void'(pick_entry(1'b0, ofs));
            send_item(OP_FREE, sz, ofs);
        end
        else if (pick < 90)
        begin
            send_item(OP_FREE, sz, ofs);
        end
        else if (pick < 95)
        begin
            void'(pick_entry(1'b1, ofs));
            send_item(OP_FREE, sz, ofs);
        end
        else if (pick < 98)
        begin
            send_item(OP_REINIT, sz, ofs);
        end
        else
        begin
            send_item(OP_NONE, sz, ofs);
        end
    endtask

    task automatic test_random_phase(int gap_pct, int stall_pct, int n);
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        repeat (n) random_beat();
    endtask

    // The receiver holds off while the sender keeps offering beats.
    task automatic test_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = 6000;
        repeat (6) random_beat();
    endtask

    task automatic test_drain_pause();
        stop_sending();
        wait_drained();
        repeat (20) random_beat();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        err_cnt = 0;
        beats_sent = 0;
        beats_checked = 0;
        alloc_fails = 0;
        bad_frees = 0;
        peak_blocks = 0;
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = 0;
        table_reset();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_phase(0, 0, 60);
        test_random_phase(61, 0, 60);
        test_backpressure();
        test_random_phase(0, 61, 60);
        test_drain_pause();
        test_random_phase(38, 38, 60);
        stop_sending();

        wait_drained();
        repeat (1200) @(posedge clk);
        $display("Sent %0d command beats, checked %0d results (%0d failed allocations,",
                 beats_sent, beats_checked, alloc_fails);
        $display("  %0d unknown offsets), table peaked at %0d blocks.",
                 bad_frees, peak_blocks);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ffba_pkg.sv
hdl/ffba_cell.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator.sv
bench/tb.sv
